### rtl/rsht_pkg.sv
// ----------------------------------------------------------------------------
// rsht_pkg: shared types and constants of the ring sensor heading tracker
// Field widths, the full-turn constant, sequencer state types and the
// command and status bundles that pass between the controller and the
// shared mean/wrap unit.
// ----------------------------------------------------------------------------
package rsht_pkg;

   localparam int HEAD_W    = 9;    // heading and sensor angle, degrees
   localparam int ANGLE_W   = 9;
   localparam int THR_W     = 10;   // detect threshold and compared sample
   localparam int HALF_W    = 8;    // window half width
   localparam int LIM_W     = 5;    // junction limit
   localparam int CNT_W     = 5;    // hit count
   localparam int SUM_W     = 14;   // signed angle sum
   localparam int DELTA_W   = 10;   // signed turn delta

   localparam int FULL_TURN = 360;

   // Divider takes one quotient bit per step; reduction tries 360 << k for k = 4..0
   localparam int DIV_STEPS = SUM_W;
   localparam int MOD_STEPS = 5;
   localparam int STEP_W    = 4;

   localparam int SENSORS_DEF     = 16;
   localparam int SAMPLE_BITS_DEF = 10;

   typedef enum logic [1:0] {
      U_IDLE,
      U_DIV,
      U_MOD,
      U_FIX
   } unit_state_type;

   typedef enum logic [2:0] {
      T_IDLE,
      T_EVAL,
      T_END,
      T_WRAP,
      T_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic start;
      logic divide;
   } unit_cmd_type;

   typedef struct packed {
      logic              done;
      logic [HEAD_W-1:0] heading;
   } unit_rsp_type;

endpackage

### rtl/rsht_mean_unit.sv
// ----------------------------------------------------------------------------
// rsht_mean_unit: iterative signed divide and wrap into 0..359
// One shared subtractor serves a restoring division by the hit count (one
// quotient bit a cycle), a reduction modulo 360 (five trial subtractions)
// and the final 360 - r fix for negative values.
// ----------------------------------------------------------------------------
module rsht_mean_unit
   import rsht_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  unit_cmd_type            cmd,
   input  logic signed [SUM_W-1:0] dividend,
   input  logic        [CNT_W-1:0] divisor,
   output unit_rsp_type            rsp
);

   unit_state_type    state_ff, state_in;
   logic              neg_ff, neg_in;
   logic [SUM_W-1:0]  work_ff, work_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  divisor_ff, divisor_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic [CNT_W:0]    rem_cat;
   logic [SUM_W-1:0]  a_op, b_op;
   logic [SUM_W:0]    diff;
   logic              borrow;
   logic              fix_done;
   logic [HEAD_W-1:0] fold_heading;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         U_IDLE: begin
            if (cmd.start) begin
               state_in = cmd.divide ? U_DIV : U_MOD;
            end
         end
         U_DIV: begin
            if (step_ff == '0) begin
               state_in = U_MOD;
            end
         end
         U_MOD: begin
            if (step_ff == '0) begin
               state_in = U_FIX;
            end
         end
         U_FIX: begin
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   // operands of the shared subtractor and status
   always_comb begin
      rem_cat  = {rem_ff, work_ff[SUM_W-1]};
      a_op     = '0;
      b_op     = '0;
      fix_done = 1'b0;
      case (state_ff)
         U_DIV: begin
            a_op = SUM_W'(rem_cat);
            b_op = SUM_W'(divisor_ff);
         end
         U_MOD: begin
            a_op = work_ff;
            b_op = SUM_W'(FULL_TURN) << step_ff;
         end
         U_FIX: begin
            a_op     = SUM_W'(FULL_TURN);
            b_op     = work_ff;
            fix_done = 1'b1;
         end
         default: begin
            a_op = '0;
            b_op = '0;
         end
      endcase
   end

   assign diff         = {1'b0, a_op} - {1'b0, b_op};
   assign borrow       = diff[SUM_W];
   // negative remainder folds back to 360 - r, a zero remainder stays zero
   assign fold_heading = (neg_ff && (work_ff != '0)) ? diff[HEAD_W-1:0]
                                                      : work_ff[HEAD_W-1:0];
   assign rsp          = {fix_done, fold_heading};

   // datapath next values
   always_comb begin
      neg_in     = neg_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      case (state_ff)
         U_IDLE: begin
            if (cmd.start) begin
               neg_in     = dividend[SUM_W-1];
               work_in    = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
               rem_in     = '0;
               divisor_in = divisor;
               step_in    = cmd.divide ? STEP_W'(DIV_STEPS - 1) : STEP_W'(MOD_STEPS - 1);
            end
         end
         U_DIV: begin
            work_in = {work_ff[SUM_W-2:0], ~borrow};
            rem_in  = borrow ? rem_cat[CNT_W-1:0] : diff[CNT_W-1:0];
            step_in = (step_ff == '0) ? STEP_W'(MOD_STEPS - 1) : step_ff - 1'b1;
         end
         U_MOD: begin
            if (!borrow) begin
               work_in = diff[SUM_W-1:0];
            end
            if (step_ff != '0) begin
               step_in = step_ff - 1'b1;
            end
         end
         default: begin
            work_in = work_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff     <= neg_in;
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      step_ff    <= step_in;
   end

endmodule

### rtl/ring_sensor_heading_tracker.sv
// ----------------------------------------------------------------------------
// ring_sensor_heading_tracker: heading tracker fed by a ring of line sensors
//
//   channel   direction   handshake                 carries
//   req_      in          req_valid / req_ready     sample or turn item
//   rsp_      out         rsp_valid / rsp_ready     heading, hits, junction flag
//   csr_      in/out      APB write at access phase threshold, window, limit
//
// A sample that does not end a scan only passes the evaluate state, the last
// one also the end and output states. A turn or heading update waits in the
// wrap state on the shared divide/wrap unit (14 divide steps for an update,
// 5 reduction steps, 1 fix step). req_ready is high only while the controller
// is idle. A result waits in the rsp_ output register; the controller holds
// in its output state only while that register is still full. Synchronous
// reset restores the register defaults and clears heading, sum and count.
// ----------------------------------------------------------------------------
module ring_sensor_heading_tracker
   import rsht_pkg::*;
#(
   parameter int SENSORS     = SENSORS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_action,
   input  logic [SAMPLE_BITS-1:0]    req_sample_value,
   input  logic [ANGLE_W-1:0]        req_sensor_angle,
   input  logic                      req_last_sample,
   input  logic                      req_apply_update,
   input  logic signed [DELTA_W-1:0] req_turn_delta,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [HEAD_W-1:0]         rsp_heading,
   output logic [CNT_W-1:0]          rsp_hits,
   output logic                      rsp_junction,
   output logic                      rsp_line_seen,

   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [3:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   localparam int VAL_W = (SAMPLE_BITS < THR_W) ? SAMPLE_BITS : THR_W;
   localparam int CAP   = (SENSORS < 31) ? SENSORS : 31;
   localparam logic [CNT_W-1:0] HIT_CAP = CNT_W'(CAP);

   localparam logic [1:0] REG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_HALF_WIDTH = 2'd1;
   localparam logic [1:0] REG_JUNCTION = 2'd2;

   localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(45);
   localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(512);
   localparam logic [LIM_W-1:0]  LIM_RESET  = LIM_W'(3);

   ctrl_state_type       state_ff, state_in;

   logic [THR_W-1:0]     thr_ff;
   logic [HALF_W-1:0]    half_ff;
   logic [LIM_W-1:0]     lim_ff;

   logic [HEAD_W-1:0]    heading_ff, heading_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   logic                 act_ff;
   logic [THR_W-1:0]     value_ff;
   logic [ANGLE_W-1:0]   angle_ff;
   logic                 last_ff;
   logic                 upd_ff;
   logic [DELTA_W-1:0]   delta_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [HEAD_W-1:0]    rsp_heading_ff;
   logic [CNT_W-1:0]     rsp_hits_ff;
   logic                 rsp_junction_ff;
   logic                 rsp_line_seen_ff;

   logic                 accept;
   logic                 rsp_load;
   logic [1:0]           csr_index;
   logic                 csr_write;

   unit_cmd_type         unit_cmd;
   unit_rsp_type         unit_rsp;
   logic [SUM_W-1:0]     unit_dividend;
   logic [SUM_W-1:0]     turn_sum;

   // window and hit evaluation
   logic [HEAD_W:0]      lo_raw, hi_raw;
   logic [HEAD_W-1:0]    lo, hi;
   logic                 crossing;
   logic                 in_window;
   logic                 hit;
   logic [ANGLE_W+1:0]   ang_ext, add;
   logic [SUM_W:0]       sum_wide;
   logic [SUM_W-1:0]     sum_sat;

   assign accept     = req_valid && req_ready;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_index)
         REG_THRESHOLD:  csr_prdata = 32'(thr_ff);
         REG_HALF_WIDTH: csr_prdata = 32'(half_ff);
         REG_JUNCTION:   csr_prdata = 32'(lim_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign lo_raw = {1'b0, heading_ff} - {2'b00, half_ff};
   assign hi_raw = {1'b0, heading_ff} + {2'b00, half_ff};
   assign lo     = lo_raw[HEAD_W] ? HEAD_W'(lo_raw + (HEAD_W+1)'(FULL_TURN)) : lo_raw[HEAD_W-1:0];
   assign hi     = (hi_raw >= (HEAD_W+1)'(FULL_TURN)) ? HEAD_W'(hi_raw - (HEAD_W+1)'(FULL_TURN))
                                                       : hi_raw[HEAD_W-1:0];
   // equal bounds count as a window across zero
   assign crossing  = !(lo < hi);
   assign in_window = crossing ? ((angle_ff >= lo) || (angle_ff <= hi))
                               : ((angle_ff >= lo) && (angle_ff <= hi));
   assign hit       = in_window && (value_ff > thr_ff) && (count_ff < HIT_CAP);

   // angles past the upper bound of a crossing window count as negative
   assign ang_ext  = {2'b00, angle_ff};
   assign add      = (!crossing || (angle_ff <= hi)) ? ang_ext
                                                     : ang_ext - (ANGLE_W+2)'(FULL_TURN);
   assign sum_wide = {sum_ff[SUM_W-1], sum_ff} + {{(SUM_W-ANGLE_W-1){add[ANGLE_W+1]}}, add};

   always_comb begin
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
   end

   assign turn_sum = {{(SUM_W-HEAD_W){1'b0}}, heading_ff}
                   + {{(SUM_W-DELTA_W){delta_ff[DELTA_W-1]}}, delta_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         T_IDLE: begin
            if (accept) begin
               state_in = T_EVAL;
            end
         end
         T_EVAL: begin
            if (act_ff) begin
               state_in = T_WRAP;
            end else if (last_ff) begin
               state_in = T_END;
            end else begin
               state_in = T_IDLE;
            end
         end
         T_END: begin
            state_in = (upd_ff && (count_ff != '0)) ? T_WRAP : T_OUT;
         end
         T_WRAP: begin
            if (unit_rsp.done) begin
               state_in = T_OUT;
            end
         end
         T_OUT: begin
            if (rsp_load) begin
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   // controller outputs
   always_comb begin
      req_ready       = 1'b0;
      unit_cmd.start  = 1'b0;
      unit_cmd.divide = 1'b0;
      unit_dividend   = turn_sum;
      rsp_load        = 1'b0;
      case (state_ff)
         T_IDLE: begin
            req_ready = 1'b1;
         end
         T_EVAL: begin
            unit_cmd.start = act_ff;
         end
         T_END: begin
            unit_cmd.start  = upd_ff && (count_ff != '0);
            unit_cmd.divide = 1'b1;
            unit_dividend   = sum_ff;
         end
         T_OUT: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   rsht_mean_unit u_mean (
      .clock    (clock),
      .reset    (reset),
      .cmd      (unit_cmd),
      .dividend (unit_dividend),
      .divisor  (count_ff),
      .rsp      (unit_rsp)
   );

   // tracker state next values
   always_comb begin
      heading_in = heading_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      if ((state_ff == T_EVAL) && !act_ff && hit) begin
         sum_in   = sum_sat;
         count_in = count_ff + 1'b1;
      end
      if ((state_ff == T_WRAP) && unit_rsp.done) begin
         heading_in = unit_rsp.heading;
      end
      // a finished scan clears its accumulators
      if (rsp_load && !act_ff) begin
         sum_in   = '0;
         count_in = '0;
      end
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         thr_ff       <= THR_RESET;
         half_ff      <= HALF_RESET;
         lim_ff       <= LIM_RESET;
         heading_ff   <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         heading_ff   <= heading_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               REG_THRESHOLD:  thr_ff  <= csr_pwdata[THR_W-1:0];
               REG_HALF_WIDTH: half_ff <= csr_pwdata[HALF_W-1:0];
               REG_JUNCTION:   lim_ff  <= csr_pwdata[LIM_W-1:0];
               default:        thr_ff  <= thr_ff;
            endcase
         end
      end
   end

   // hold the accepted item for the length of its work
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff   <= req_action;
         value_ff <= THR_W'(req_sample_value[VAL_W-1:0]);
         angle_ff <= req_sensor_angle;
         last_ff  <= req_last_sample;
         upd_ff   <= req_apply_update;
         delta_ff <= req_turn_delta;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_heading_ff   <= heading_ff;
         rsp_hits_ff      <= act_ff ? '0 : count_ff;
         rsp_junction_ff  <= !act_ff && (count_ff > lim_ff);
         rsp_line_seen_ff <= !act_ff && (count_ff != '0);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_heading   = rsp_heading_ff;
   assign rsp_hits      = rsp_hits_ff;
   assign rsp_junction  = rsp_junction_ff;
   assign rsp_line_seen = rsp_line_seen_ff;

endmodule
